### rtl/fpr_pkg.sv
// shared types and constants for the framed packet receiver
// parse phase codes, configuration indexes, controller/datapath command and status
// no dependencies
package fpr_pkg;

  localparam int PAYLOAD_BUFFER_DEF = 64;
  localparam int LEN_OVERHEAD       = 10;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd165;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd252;
  localparam logic [7:0]  TAIL_VALUE_RST    = 8'd251;
  localparam logic [15:0] GAP_TIMEOUT_RST   = 16'd1000;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_TAIL_VALUE    = 2'd2,
    CFG_GAP_TIMEOUT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_HEAD0   = 4'd0,
    PH_HEAD1   = 4'd1,
    PH_LEN0    = 4'd2,
    PH_LEN1    = 4'd3,
    PH_TYPE    = 4'd4,
    PH_CMD     = 4'd5,
    PH_SEQ     = 4'd6,
    PH_DATA    = 4'd7,
    PH_SUM0    = 4'd8,
    PH_SUM1    = 4'd9,
    PH_TAIL    = 4'd10,
    ST_READ    = 4'd11,
    ST_SHOW    = 4'd12
  } phase_t;

  typedef struct packed {
    logic accept;
    logic len_low_ld;
    logic len_ld;
    logic type_ld;
    logic cmd_ld;
    logic seq_ld;
    logic data_wr;
    logic sum_low_ld;
    logic emit_start;
    logic rd_en;
    logic idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic gap_expired;
    logic hdr1_hit;
    logic hdr2_hit;
    logic tail_hit;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic emit_last;
  } dp_stat_t;

endpackage

### rtl/fpr_datapath.sv
// datapath of the framed packet receiver: config registers, header fields,
// checksum, payload store and readout index; driven by fpr_ctrl
// depends on fpr_pkg
module fpr_datapath
  import fpr_pkg::*;
#(
  parameter int PAYLOAD_BUFFER = PAYLOAD_BUFFER_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           now_ms,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [7:0]            frame_type,
  output logic [7:0]            frame_command,
  output logic [7:0]            frame_sequence,
  output logic [5:0]            payload_length,
  output logic [5:0]            payload_index,
  output logic [7:0]            payload_byte
);

  localparam int MAX_LEN = PAYLOAD_BUFFER - LEN_OVERHEAD;
  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int AW      = $clog2(PAYLOAD_BUFFER);

  logic [7:0]    header_first;
  logic [7:0]    header_second;
  logic [7:0]    tail_value;
  logic [15:0]   gap_timeout_ms;

  logic [31:0]   last_byte_time;
  logic [7:0]    length_low_byte;
  logic [CW-1:0] frame_length;
  logic [7:0]    held_type;
  logic [7:0]    held_command;
  logic [7:0]    held_sequence;
  logic [CW-1:0] bytes_received;
  logic [15:0]   running_sum;
  logic [7:0]    sum_low_byte;
  logic [CW-1:0] rd_idx;
  logic [7:0]    rd_data;

  logic [7:0]    payload_store [PAYLOAD_BUFFER];

  logic [31:0]   elapsed;
  logic [15:0]   len_word;
  logic [CW:0]   recv_plus;
  logic [CW:0]   idx_plus;
  logic [15:0]   len_wide;
  logic [15:0]   idx_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first   <= HEADER_FIRST_RST;
      header_second  <= HEADER_SECOND_RST;
      tail_value     <= TAIL_VALUE_RST;
      gap_timeout_ms <= GAP_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_HEADER_FIRST:  header_first   <= cfg_data[7:0];
        CFG_HEADER_SECOND: header_second  <= cfg_data[7:0];
        CFG_TAIL_VALUE:    tail_value     <= cfg_data[7:0];
        CFG_GAP_TIMEOUT:   gap_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte_time <= '0;
    end else if (cmd.accept) begin
      last_byte_time <= now_ms;
    end
  end

  assign elapsed   = now_ms - last_byte_time;
  assign len_word  = {rx_byte, length_low_byte};
  assign recv_plus = {1'b0, bytes_received} + 1'b1;
  assign idx_plus  = {1'b0, rd_idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.len_low_ld) length_low_byte <= rx_byte;
    if (cmd.len_ld)     frame_length    <= len_word[CW-1:0];
    if (cmd.type_ld) begin
      held_type   <= rx_byte;
      running_sum <= {8'd0, rx_byte};
    end
    if (cmd.cmd_ld) begin
      held_command <= rx_byte;
      running_sum  <= running_sum + {8'd0, rx_byte};
    end
    if (cmd.seq_ld) begin
      held_sequence  <= rx_byte;
      running_sum    <= running_sum + {8'd0, rx_byte};
      bytes_received <= '0;
    end
    if (cmd.data_wr) begin
      running_sum    <= running_sum + {8'd0, rx_byte};
      bytes_received <= recv_plus[CW-1:0];
    end
    if (cmd.sum_low_ld) sum_low_byte <= rx_byte;
    if (cmd.emit_start) rd_idx <= '0;
    else if (cmd.idx_inc) rd_idx <= idx_plus[CW-1:0];
  end

  // payload store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.data_wr) payload_store[AW'(bytes_received)] <= rx_byte;
    if (cmd.rd_en)   rd_data <= payload_store[AW'(rd_idx)];
  end

  always_comb begin
    stat.gap_expired = elapsed > {16'd0, gap_timeout_ms};
    stat.hdr1_hit    = rx_byte == header_first;
    stat.hdr2_hit    = rx_byte == header_second;
    stat.tail_hit    = rx_byte == tail_value;
    stat.len_ok      = len_word <= 16'(MAX_LEN);
    stat.len_zero    = frame_length == '0;
    stat.data_done   = recv_plus >= {1'b0, frame_length};
    stat.sum_ok      = {rx_byte, sum_low_byte} == running_sum;
    stat.emit_last   = (frame_length == '0) || (idx_plus == {1'b0, frame_length});
  end

  assign len_wide       = 16'(frame_length);
  assign idx_wide       = 16'(rd_idx);
  assign frame_type     = held_type;
  assign frame_command  = held_command;
  assign frame_sequence = held_sequence;
  assign payload_length = len_wide[5:0];
  assign payload_index  = idx_wide[5:0];
  assign payload_byte   = (frame_length == '0) ? 8'd0 : rd_data;

endmodule

### rtl/fpr_ctrl.sv
// controller of the framed packet receiver: parse phase and payload readout
// state machine, issues datapath commands from datapath status
// depends on fpr_pkg
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  phase_t state;
  phase_t state_next;
  phase_t phase_eff;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_HEAD0;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state != ST_READ) && (state != ST_SHOW);
  assign out_valid = state == ST_SHOW;
  assign acc       = in_valid && in_ready;
  // a long gap restarts the hunt before the byte is used
  assign phase_eff = stat.gap_expired ? PH_HEAD0 : state;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.accept = acc;
    if (state == ST_READ) begin
      cmd.rd_en  = 1'b1;
      state_next = ST_SHOW;
    end else if (state == ST_SHOW) begin
      if (out_ready) begin
        if (stat.emit_last) begin
          state_next = PH_HEAD0;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_READ;
        end
      end
    end else if (acc) begin
      unique case (phase_eff)
        PH_HEAD0: state_next = stat.hdr1_hit ? PH_HEAD1 : PH_HEAD0;
        PH_HEAD1: begin
          if (stat.hdr2_hit) state_next = PH_LEN0;
          else if (!stat.hdr1_hit) state_next = PH_HEAD0;
          else state_next = PH_HEAD1;
        end
        PH_LEN0: begin
          cmd.len_low_ld = 1'b1;
          state_next     = PH_LEN1;
        end
        PH_LEN1: begin
          cmd.len_ld = stat.len_ok;
          state_next = stat.len_ok ? PH_TYPE : PH_HEAD0;
        end
        PH_TYPE: begin
          cmd.type_ld = 1'b1;
          state_next  = PH_CMD;
        end
        PH_CMD: begin
          cmd.cmd_ld = 1'b1;
          state_next = PH_SEQ;
        end
        PH_SEQ: begin
          cmd.seq_ld = 1'b1;
          state_next = stat.len_zero ? PH_SUM0 : PH_DATA;
        end
        PH_DATA: begin
          cmd.data_wr = 1'b1;
          state_next  = stat.data_done ? PH_SUM0 : PH_DATA;
        end
        PH_SUM0: begin
          cmd.sum_low_ld = 1'b1;
          state_next     = PH_SUM1;
        end
        PH_SUM1: state_next = stat.sum_ok ? PH_TAIL : PH_HEAD0;
        PH_TAIL: begin
          if (stat.tail_hit) begin
            cmd.emit_start = 1'b1;
            state_next     = stat.len_zero ? ST_SHOW : ST_READ;
          end else begin
            state_next = PH_HEAD0;
          end
        end
        default: state_next = PH_HEAD0;
      endcase
    end
  end

endmodule

### rtl/framed_packet_receiver_top.sv
// top level of the framed packet receiver
// instantiates fpr_ctrl and fpr_datapath; depends on fpr_pkg

// Byte-serial frame deframer. Each input beat carries one received byte and the
// millisecond time it arrived; a gap longer than gap_timeout_ms restarts the
// hunt for the first header byte. Frames are header_first, header_second,
// 16-bit little-endian length (at most PAYLOAD_BUFFER-10), type, command,
// sequence, payload, 16-bit little-endian sum of type, command, sequence and
// payload, and tail_value. A good frame gives one output beat per payload
// byte, or one empty beat when the length is zero, with tlast on the final
// beat. Header, length, checksum and payload bytes can be taken back to back.
// After a good tail byte each payload byte is walked out as a store read (the
// store's read port is registered) and then an output beat held until taken,
// and no input beat is taken until the last output beat has left.
// Configuration writes are taken at any time but belong to idle spells.
module framed_packet_receiver_top
  import fpr_pkg::*;
#(
  parameter int PAYLOAD_BUFFER = PAYLOAD_BUFFER_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,   // rx_byte[7:0], now_ms[39:8]
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // frame_type[7:0], frame_command[15:8], frame_sequence[23:16],
  // payload_length[29:24], payload_index[35:30], payload_byte[43:36], zero pad
  output logic [47:0]           m_axis_tdata,
  output logic                  m_axis_tlast    // last
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] frame_type;
  logic [7:0] frame_command;
  logic [7:0] frame_sequence;
  logic [5:0] payload_length;
  logic [5:0] payload_index;
  logic [7:0] payload_byte;

  // phase sequencing and readout handshakes
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // config, header fields, checksum and payload store
  fpr_datapath #(
    .PAYLOAD_BUFFER (PAYLOAD_BUFFER)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .rx_byte        (s_axis_tdata[7:0]),
    .now_ms         (s_axis_tdata[39:8]),
    .cmd            (cmd),
    .stat           (stat),
    .frame_type     (frame_type),
    .frame_command  (frame_command),
    .frame_sequence (frame_sequence),
    .payload_length (payload_length),
    .payload_index  (payload_index),
    .payload_byte   (payload_byte)
  );

  // pack result fields, lowest first, padded to whole bytes
  assign m_axis_tdata = {4'd0, payload_byte, payload_index, payload_length,
                         frame_sequence, frame_command, frame_type};
  // last beat of the frame
  assign m_axis_tlast = stat.emit_last;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for framed_packet_receiver_top: byte frames in, payload beats out
// keeps its own deframer model and compares every output beat in order; needs fpr_pkg

module testbench;
  import fpr_pkg::*;

  localparam int MAX_LEN       = PAYLOAD_BUFFER_DEF - LEN_OVERHEAD;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  // one output beat as the block packs it
  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] frame_command;
    logic [7:0] frame_sequence;
    logic [5:0] payload_length;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    logic       last;
  } beat_t;

  typedef logic [7:0] byte_q_t[$];

  // ways a frame can be spoiled on the wire
  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL, FR_TOO_LONG, FR_GAP} frame_flaw_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  always #5 clk = ~clk;

  framed_packet_receiver_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // register copies as the block should hold them
  logic [7:0]  hdr_first  = HEADER_FIRST_RST;
  logic [7:0]  hdr_second = HEADER_SECOND_RST;
  logic [7:0]  tail_byte  = TAIL_VALUE_RST;
  logic [15:0] gap_limit  = GAP_TIMEOUT_RST;

  // deframer state mirrored from the block
  phase_t      rx_phase   = PH_HEAD0;
  logic [7:0]  rx_len_lo  = '0;
  logic [15:0] rx_len     = '0;
  logic [7:0]  rx_type    = '0;
  logic [7:0]  rx_cmd     = '0;
  logic [7:0]  rx_seq     = '0;
  int          rx_count   = 0;
  logic [7:0]  rx_store [PAYLOAD_BUFFER_DEF];
  logic [15:0] rx_sum     = '0;
  logic [7:0]  rx_sum_lo  = '0;
  logic [31:0] rx_last_ms = '0;

  beat_t expected_beats[$];

  // stimulus knobs and run statistics
  logic [31:0] now_ms        = '0;
  bit          idle_on       = 1'b1;
  bit          sink_stalls   = 1'b1;
  bit          pace_at_limit = 1'b0;
  int          sink_hold     = 0;
  int          bytes_sent    = 0;
  int          frames_sent   = 0;
  int          beats_checked = 0;
  int          reg_settings  = 1;
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // deframer model: one received byte in, the payload beats it releases pushed
  // ---------------------------------------------------------------------------
  function automatic void deframe_byte(logic [7:0] b, logic [31:0] t);
    logic [31:0] elapsed;
    logic [15:0] len;
    elapsed    = t - rx_last_ms;
    rx_last_ms = t;
    // a long silence always sends the parser back to the sync hunt
    if (elapsed > 32'(gap_limit)) rx_phase = PH_HEAD0;
    case (rx_phase)
      PH_HEAD0: rx_phase = (b == hdr_first) ? PH_HEAD1 : PH_HEAD0;
      PH_HEAD1: begin
        // a repeated first sync byte keeps us waiting for the second
        if (b == hdr_second) rx_phase = PH_LEN0;
        else if (b != hdr_first) rx_phase = PH_HEAD0;
      end
      PH_LEN0: begin
        rx_len_lo = b;
        rx_phase  = PH_LEN1;
      end
      PH_LEN1: begin
        len = {b, rx_len_lo};
        if (32'(len) <= 32'(MAX_LEN)) begin
          rx_len   = len;
          rx_phase = PH_TYPE;
        end else begin
          rx_phase = PH_HEAD0;
        end
      end
      PH_TYPE: begin
        rx_type  = b;
        rx_sum   = 16'(b);
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        rx_cmd   = b;
        rx_sum   = rx_sum + 16'(b);
        rx_phase = PH_SEQ;
      end
      PH_SEQ: begin
        rx_seq   = b;
        rx_sum   = rx_sum + 16'(b);
        rx_count = 0;
        rx_phase = (rx_len != 16'd0) ? PH_DATA : PH_SUM0;
      end
      PH_DATA: begin
        if (rx_count < PAYLOAD_BUFFER_DEF) rx_store[rx_count] = b;
        rx_sum   = rx_sum + 16'(b);
        rx_count = rx_count + 1;
        if (rx_count >= int'(rx_len)) rx_phase = PH_SUM0;
      end
      PH_SUM0: begin
        rx_sum_lo = b;
        rx_phase  = PH_SUM1;
      end
      PH_SUM1: rx_phase = ({b, rx_sum_lo} == rx_sum) ? PH_TAIL : PH_HEAD0;
      PH_TAIL: begin
        if (b == tail_byte) begin
          if (rx_len == 16'd0) begin
            expected_beats.push_back(beat_t'{rx_type, rx_cmd, rx_seq, 6'd0, 6'd0, 8'd0, 1'b1});
          end else begin
            for (int i = 0; i < int'(rx_len) && i < PAYLOAD_BUFFER_DEF; i++)
              expected_beats.push_back(beat_t'{rx_type, rx_cmd, rx_seq, rx_len[5:0], 6'(i),
                                               rx_store[i], 1'(i + 1 == int'(rx_len))});
          end
        end
        rx_phase = PH_HEAD0;
      end
      default: rx_phase = PH_HEAD0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // small random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic byte_q_t rand_body(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(rand_byte());
    return q;
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // time step between bytes, never beyond the gap limit; exactly at it when asked
  function automatic logic [31:0] pace();
    if (pace_at_limit) return 32'(gap_limit);
    if (gap_limit == 16'd0) return 32'd0;
    if ($urandom_range(0, 15) == 0) return 32'(gap_limit);
    return $urandom_range(0, (gap_limit < 16'd5) ? 32'(gap_limit) : 32'd5);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: inputs change on the falling edge, handshakes seen on the rising
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic [31:0] delta);
    int idle;
    idle   = idle_len();
    now_ms = now_ms + delta;
    if (idle > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now_ms, b};
    do @(posedge clk); while (!s_axis_tready);
    deframe_byte(b, now_ms);
    bytes_sent++;
  endtask

  // whole frame on the wire, optionally spoiled in one way
  task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] ftype, fcmd, fseq,
                            input byte_q_t body);
    byte_q_t     wire_q;
    logic [15:0] len_field;
    logic [15:0] csum;
    logic [7:0]  tl;
    int          cut;
    csum = 16'(ftype) + 16'(fcmd) + 16'(fseq);
    foreach (body[i]) csum = csum + 16'(body[i]);
    len_field = 16'(body.size());
    tl        = tail_byte;
    case (flaw)
      FR_TOO_LONG: len_field = 16'($urandom_range(MAX_LEN + 1, 16'hFFFF));
      FR_BAD_SUM:  csum = csum ^ (16'd1 << $urandom_range(0, 15));
      FR_BAD_TAIL: tl = tl ^ (8'd1 << $urandom_range(0, 7));
      default: ;
    endcase
    wire_q = {hdr_first, hdr_second, len_field[7:0], len_field[15:8], ftype, fcmd, fseq};
    foreach (body[i]) wire_q.push_back(body[i]);
    wire_q.push_back(csum[7:0]);
    wire_q.push_back(csum[15:8]);
    wire_q.push_back(tl);
    // for a gap flaw one byte after the first arrives too late
    cut = (flaw == FR_GAP) ? int'($urandom_range(1, wire_q.size() - 1)) : -1;
    foreach (wire_q[i])
      send_byte(wire_q[i], (i == cut) ? 32'(gap_limit) + 32'd1 + $urandom_range(0, 100)
                                      : pace());
    frames_sent++;
  endtask

  // stop offering, let every expected beat out, then let the block stand quiet
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:  hdr_first  = val[7:0];
      CFG_HEADER_SECOND: hdr_second = val[7:0];
      CFG_TAIL_VALUE:    tail_byte  = val[7:0];
      CFG_GAP_TIMEOUT:   gap_limit  = val;
      default: ;
    endcase
  endtask

  // registers only change once the block has gone quiet
  task automatic set_registers(input logic [7:0] hf, hs, tl, input logic [15:0] to);
    settle();
    write_reg(CFG_HEADER_FIRST, 16'(hf));
    write_reg(CFG_HEADER_SECOND, 16'(hs));
    write_reg(CFG_TAIL_VALUE, 16'(tl));
    write_reg(CFG_GAP_TIMEOUT, to);
    reg_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random ready, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : sink
    int n;
    bit rdy;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        rdy       = 1'b0;
        n         = sink_hold;
        sink_hold = 0;
      end else if (!sink_stalls || $urandom_range(0, 3) != 0) begin
        rdy = 1'b1;
        n   = $urandom_range(1, 6);
      end else begin
        rdy = 1'b0;
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      m_axis_tready <= rdy;
      repeat (n - 1) @(negedge clk);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // every output beat against the oldest expected one
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing expected: tdata %h tlast %b", m_axis_tdata,
               m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        check_field("frame_type", want.frame_type, m_axis_tdata[7:0]);
        check_field("frame_command", want.frame_command, m_axis_tdata[15:8]);
        check_field("frame_sequence", want.frame_sequence, m_axis_tdata[23:16]);
        check_field("payload_length", 8'(want.payload_length), 8'(m_axis_tdata[29:24]));
        check_field("payload_index", 8'(want.payload_index), 8'(m_axis_tdata[35:30]));
        check_field("payload_byte", want.payload_byte, m_axis_tdata[43:36]);
        check_field("last", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_beats.size());
      $display("** framed_packet_receiver_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: empty frame and extreme field values
  task automatic test_default_frames();
    byte_q_t body;
    body = {};
    send_frame(FR_GOOD, 8'h00, 8'h00, 8'h00, body);
    body = {8'h00, 8'hFF, 8'h5A};
    send_frame(FR_GOOD, 8'hFF, 8'hFF, 8'hFF, body);
  endtask

  // sync hunt: repeated first header, and a stray byte between the headers
  task automatic test_header_hunt();
    send_byte(hdr_first, pace());
    send_byte(hdr_first, pace());
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(0));
    send_byte(hdr_first, pace());
    send_byte(8'h00, pace());
    send_byte(hdr_second, pace());
    send_byte(8'h01, pace());
    send_byte(8'h00, pace());
    send_frame(FR_GOOD, 8'h10, 8'h20, 8'h30, rand_body(1));
  endtask

  // oversize length, bad checksum, bad tail; each drop must leave the hunt clean
  task automatic test_dropped_frames();
    send_byte(hdr_first, pace());
    send_byte(hdr_second, pace());
    send_byte(8'(MAX_LEN + 1), pace());
    send_byte(8'h00, pace());
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(0));
    send_frame(FR_BAD_SUM, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    send_frame(FR_BAD_TAIL, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    send_frame(FR_TOO_LONG, rand_byte(), rand_byte(), rand_byte(), rand_body(0));
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
  endtask

  // a late byte mid-frame, then bytes spaced exactly at the limit
  task automatic test_gap_timeout();
    send_frame(FR_GAP, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(0));
    pace_at_limit = 1'b1;
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    pace_at_limit = 1'b0;
  endtask

  // register extremes, including identical sync bytes
  task automatic test_register_extremes();
    set_registers(8'h00, 8'hFF, 8'h00, 16'd0);
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    set_registers(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
    pace_at_limit = 1'b1;
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    pace_at_limit = 1'b0;
    set_registers(8'h7E, 8'h7E, 8'h7E, 16'd20);
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
  endtask

  // millisecond counter rolls over in the middle of a frame
  task automatic test_time_wrap();
    set_registers(HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_VALUE_RST, GAP_TIMEOUT_RST);
    now_ms = 32'hFFFF_FFFC;
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(2));
  endtask

  // receiver holds off while a full-size frame comes out and the next one queues up
  task automatic test_output_backpressure();
    idle_on   = 1'b0;
    sink_hold = 250;
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(MAX_LEN));
    send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(), rand_body(1));
    idle_on = 1'b1;
  endtask

  // no gaps and no stalls on either side
  task automatic test_back_to_back();
    settle();
    idle_on     = 1'b0;
    sink_stalls = 1'b0;
    repeat (2)
      send_frame(FR_GOOD, rand_byte(), rand_byte(), rand_byte(),
                 rand_body($urandom_range(0, 2)));
    settle();
    idle_on     = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // mostly good frames with random content, some spoiled, some noise and time jumps
  task automatic test_random_traffic();
    logic [15:0] to;
    int          start;
    int          r;
    int          n;
    frame_flaw_t flaw;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       to = 16'($urandom_range(0, 65535));
        1:       to = 16'($urandom_range(0, 3));
        default: to = GAP_TIMEOUT_RST;
      endcase
      set_registers(rand_byte(), rand_byte(), rand_byte(), to);
      start = bytes_sent;
      while (bytes_sent - start < 10) begin
        if ($urandom_range(0, 9) == 0) now_ms = $urandom;
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4)) send_byte(rand_byte(), pace());
        r = $urandom_range(0, 19);
        if (r < 16) n = $urandom_range(0, 8);
        else if (r < 19) n = $urandom_range(9, 30);
        else n = MAX_LEN - $urandom_range(0, 1);
        flaw = ($urandom_range(0, 9) < 7) ? FR_GOOD : frame_flaw_t'($urandom_range(1, 4));
        send_frame(flaw, rand_byte(), rand_byte(), rand_byte(), rand_body(n));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_HEADER_FIRST;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_frames();
    test_header_hunt();
    test_dropped_frames();
    test_gap_timeout();
    test_register_extremes();
    test_time_wrap();
    test_output_backpressure();
    test_back_to_back();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);

    $display("run: %0d bytes in %0d frames over %0d register settings, %0d beats checked",
             bytes_sent, frames_sent, reg_settings, beats_checked);
    $display("run: sync hunt, length/checksum/tail drops, gap timeouts, time wrap, output hold");
    if (fail_count == 0) begin
      $display("** framed_packet_receiver_top: PASSED **");
    end else begin
      $display("** framed_packet_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule

### framed_packet_receiver_top.f
rtl/fpr_pkg.sv
rtl/fpr_datapath.sv
rtl/fpr_ctrl.sv
rtl/framed_packet_receiver_top.sv
test/testbench.sv
